/* design/pkbaf_pkg.sv */
package pkbaf_pkg;

  localparam int KEYS           = 64;
  localparam int DEFAULT_FACTOR = 4;
  localparam int KEY_AW         = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int SUM_W          = 24;
  localparam int STEP_W         = $clog2(SUM_W);

  localparam logic [1:0] OP_PROCESS    = 2'd0;
  localparam logic [1:0] OP_SET_FACTOR = 2'd1;
  localparam logic [1:0] OP_CLEAR      = 2'd2;
  localparam logic [1:0] OP_QUERY      = 2'd3;

  typedef struct packed {
    logic [SUM_W-1:0] wsum;
    logic [7:0]       wcount;
    logic [15:0]      wlast;
    logic [7:0]       wfactor;
  } entry_t;

  function automatic logic [7:0] nz_factor(input logic [7:0] f);
    nz_factor = (f == 8'd0) ? 8'd1 : f;
  endfunction

  localparam entry_t RESET_ENTRY = '{
    wsum: '0, wcount: 8'd0, wlast: 16'd0, wfactor: nz_factor(8'(DEFAULT_FACTOR))
  };

endpackage

/* design/pkbaf_div.sv */
module pkbaf_div import pkbaf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [7:0]       divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  q_r;
  logic [7:0]        rem_r;
  logic [7:0]        divisor_r;
  logic [8:0]        trial;
  logic [8:0]        diff;
  logic              ge;

  // restoring divide, one quotient bit per cycle
  assign trial = {rem_r, q_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, divisor_r};
  assign diff  = trial - {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r       <= dividend;
      rem_r     <= 8'd0;
      divisor_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[7:0] : trial[7:0];
      q_r   <= {q_r[SUM_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

/* design/per_key_block_average_filter.sv */
// a sample word on an in-range key runs S_EXEC, the divider in S_DIV, then S_WB;
// other words go from S_EXEC straight to S_WB; one word at a time, bound by the 24-step
// serial divider; a result not yet taken at the output holds the word in S_WB;
// in_ready drops after accept and returns once the result is in the output register
// reset clears control state and the per-key valid bits, so all keys read as
// zero sums with the default factor; no clearing pass is needed
module per_key_block_average_filter import pkbaf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_key,
  input  logic [15:0] in_sample,
  input  logic [7:0]  in_window_factor,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic        out_window_done,
  output logic [15:0] out_average,
  output logic [7:0]  out_count_now,
  output logic [15:0] out_last_value,
  output logic [7:0]  out_factor_now
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  entry_t            mem [KEYS];
  logic [KEYS-1:0]   vld_r;
  entry_t            rd_r;
  logic              rdv_r;
  logic [1:0]        op_r;
  logic              oor_r;
  logic [KEY_AW-1:0] idx_r;
  logic [15:0]       sample_r;
  logic [7:0]        newf_r;
  entry_t            work_r;
  logic [7:0]        cnt_r;
  logic              wdone_r;
  logic [15:0]       avg_r;

  logic              out_valid_r;
  logic              ok_r;
  logic              odone_r;
  logic [15:0]       oavg_r;
  logic [7:0]        ocount_r;
  logic [15:0]       olast_r;
  logic [7:0]        ofactor_r;

  logic              accept;
  logic              out_free;
  logic              wb_fire;
  entry_t            cur;
  logic [SUM_W-1:0]  proc_sum;
  logic [7:0]        proc_cnt;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_q;
  logic [7:0]        f_eff;
  logic [7:0]        cnt_mod;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign wb_fire  = (state_r == S_WB) && out_free;

  // an entry never written since reset reads as the reset value
  assign cur       = rdv_r ? rd_r : RESET_ENTRY;
  assign proc_sum  = cur.wsum + SUM_W'(sample_r);
  assign proc_cnt  = cur.wcount + 8'd1;
  assign div_start = (state_r == S_EXEC) && !oor_r && (op_r == OP_PROCESS);

  // count stays below the factor, so one subtract gives the modulo
  assign f_eff   = nz_factor(work_r.wfactor);
  assign cnt_mod = (cnt_r >= f_eff) ? cnt_r - f_eff : cnt_r;

  pkbaf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (proc_sum),
    .divisor  (proc_cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: state_nxt = div_start ? S_DIV : S_WB;
      S_DIV:  if (div_done) state_nxt = S_WB;
      S_WB:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wb_fire && !oor_r) vld_r[idx_r] <= 1'b1;
      if (wb_fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // key store: read on accept, written back for in-range keys when the result is handed over
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r  <= mem[in_key[KEY_AW-1:0]];
      rdv_r <= vld_r[in_key[KEY_AW-1:0]];
    end
    if (wb_fire && !oor_r) mem[idx_r] <= work_r;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_opcode;
      oor_r    <= in_key >= 8'(KEYS);
      idx_r    <= in_key[KEY_AW-1:0];
      sample_r <= in_sample;
      newf_r   <= in_window_factor;
    end
    if (state_r == S_EXEC) begin
      wdone_r <= 1'b0;
      avg_r   <= 16'd0;
      cnt_r   <= proc_cnt;
      case (op_r)
        OP_PROCESS:    work_r <= '{wsum: proc_sum, wcount: cur.wcount, wlast: cur.wlast,
                                   wfactor: cur.wfactor};
        OP_SET_FACTOR: work_r <= '{wsum: '0, wcount: 8'd0, wlast: 16'd0,
                                   wfactor: nz_factor(newf_r)};
        OP_CLEAR:      work_r <= '{wsum: '0, wcount: 8'd0, wlast: 16'd0,
                                   wfactor: cur.wfactor};
        default:       work_r <= cur;
      endcase
    end
    if (state_r == S_DIV && div_done) begin
      avg_r         <= div_q[15:0];
      work_r.wlast  <= div_q[15:0];
      work_r.wcount <= cnt_mod;
      if (cnt_mod == 8'd0) begin
        work_r.wsum <= '0;
        wdone_r     <= 1'b1;
      end
    end
    if (wb_fire) begin
      ok_r      <= !oor_r;
      odone_r   <= oor_r ? 1'b0 : wdone_r;
      oavg_r    <= oor_r ? 16'd0 : avg_r;
      ocount_r  <= oor_r ? 8'd0 : work_r.wcount;
      olast_r   <= oor_r ? 16'd0 : work_r.wlast;
      ofactor_r <= oor_r ? 8'd0 : work_r.wfactor;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_window_done = odone_r;
  assign out_average     = oavg_r;
  assign out_count_now   = ocount_r;
  assign out_last_value  = olast_r;
  assign out_factor_now  = ofactor_r;

endmodule

/* design/pkbaf_checker.sv */
module pkbaf_props import pkbaf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_ok,
  input logic        out_window_done,
  input logic [15:0] out_average,
  input logic [7:0]  out_count_now,
  input logic [15:0] out_last_value,
  input logic [7:0]  out_factor_now
);

  // a held result word keeps its count and average
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count_now) && $stable(out_average))
    else $error("result word changed while stalled");

  // one word in flight: no accept on the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

  // rejected key reports all zeros
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> !out_window_done && out_average == 16'd0 &&
      out_count_now == 8'd0 && out_last_value == 16'd0 && out_factor_now == 8'd0)
    else $error("rejected key returned nonzero fields");

  // applied word: factor nonzero and count below it
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |-> out_factor_now != 8'd0 && out_count_now < out_factor_now)
    else $error("count not below factor");

  // a completed window leaves the count at zero
  a_window_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_done |-> out_ok && out_count_now == 8'd0)
    else $error("window done without count wrap");

endmodule

bind per_key_block_average_filter pkbaf_props u_pkbaf_props (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_ok          (out_ok),
  .out_window_done (out_window_done),
  .out_average     (out_average),
  .out_count_now   (out_count_now),
  .out_last_value  (out_last_value),
  .out_factor_now  (out_factor_now)
);
